FILE: src/cgrg_pkg.sv
// Shared widths, the side-band record and output helpers for the complex Givens
// rotation generator. Depends on nothing; used by every file in src.
package cgrg_pkg;

    localparam int IN_W       = 32;
    localparam int Q30_W      = 32;
    localparam int ROT_W      = 34;
    localparam int NUM_W      = 96;
    localparam int RAD_W      = 128;
    localparam int ROOT_W     = 64;
    localparam int REM_W      = ROOT_W + 2;
    localparam int DEN_W      = ROOT_W + 1;
    localparam int QW         = 35;
    localparam int N2_W       = DEN_W + QW;
    localparam int LANES      = 5;
    localparam int NORM_STEPS = 6;
    localparam int SHC_W      = 7;
    localparam int EXP_W      = 6;
    localparam int FRONT      = 6;
    localparam int NSTG       = FRONT + NORM_STEPS + ROOT_W + 1 + QW;
    localparam int IN_DATA_W  = 4 * IN_W;
    localparam int OUT_DATA_W = 3 * Q30_W + 2 * ROT_W + 4;

    localparam logic [QW-1:0] ONE_Q30 = QW'(1) << 30;

    localparam int LANE_COS = 0;
    localparam int LANE_SRE = 1;
    localparam int LANE_SIM = 2;
    localparam int LANE_RRE = 3;
    localparam int LANE_RIM = 4;

    typedef logic [LANES-1:0][NUM_W-1:0] t_nums;

    typedef struct packed {
        logic                    gz;
        logic signed [IN_W-1:0]  fr;
        logic signed [IN_W-1:0]  fi;
        logic [LANES-1:0]        neg;
        logic [EXP_W-1:0]        e;
        t_nums                   num;
    } t_side;

    function automatic logic [Q30_W-1:0] q30_clamp(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] m;
        logic [QW-1:0] s;
        m = (q > ONE_Q30) ? ONE_Q30 : q;
        s = neg ? (~m + QW'(1)) : m;
        return s[Q30_W-1:0];
    endfunction

    function automatic logic [ROT_W-1:0] rot_sign(input logic neg, input logic [QW-1:0] q);
        logic [QW-1:0] s;
        s = neg ? (~q + QW'(1)) : q;
        return s[ROT_W-1:0];
    endfunction

endpackage

FILE: src/cgrg_sqrt_cell.sv
// One digit cell of the integer square-root chain: resolves one root bit per cycle while i_en is high.
// Depends on cgrg_pkg for widths.
module cgrg_sqrt_cell (
    input  logic                          i_clk,
    input  logic                          i_en,
    input  logic [cgrg_pkg::REM_W-1:0]    i_rem,
    input  logic [cgrg_pkg::ROOT_W-1:0]   i_root,
    input  logic [cgrg_pkg::RAD_W-1:0]    i_x,
    output logic [cgrg_pkg::REM_W-1:0]    o_rem,
    output logic [cgrg_pkg::ROOT_W-1:0]   o_root,
    output logic [cgrg_pkg::RAD_W-1:0]    o_x
);

    logic [cgrg_pkg::REM_W-1:0] w_rem2;
    logic [cgrg_pkg::REM_W-1:0] w_trial;
    logic                       w_ge;

    always_comb begin
        w_rem2  = {i_rem[cgrg_pkg::REM_W-3:0], i_x[cgrg_pkg::RAD_W-1 -: 2]};
        w_trial = {i_root, 2'b01};
        w_ge    = (w_rem2 >= w_trial);
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_ge ? (w_rem2 - w_trial) : w_rem2;
            o_root <= {i_root[cgrg_pkg::ROOT_W-2:0], w_ge};
            o_x    <= {i_x[cgrg_pkg::RAD_W-3:0], 2'b00};
        end
    end

endmodule

FILE: src/cgrg_div_cell.sv
// One restoring-division cell: brings in one dividend bit and yields one quotient bit.
// Depends on cgrg_pkg for widths.
module cgrg_div_cell (
    input  logic                        i_clk,
    input  logic                        i_en,
    input  logic [cgrg_pkg::DEN_W-1:0]  i_rem,
    input  logic [cgrg_pkg::QW-1:0]     i_word,
    input  logic [cgrg_pkg::DEN_W-1:0]  i_den,
    output logic [cgrg_pkg::DEN_W-1:0]  o_rem,
    output logic [cgrg_pkg::QW-1:0]     o_word
);

    logic [cgrg_pkg::DEN_W:0] w_r2;
    logic [cgrg_pkg::DEN_W:0] w_d;
    logic [cgrg_pkg::DEN_W:0] w_diff;
    logic                     w_ge;

    always_comb begin
        w_r2   = {i_rem, i_word[cgrg_pkg::QW-1]};
        w_d    = {1'b0, i_den};
        w_ge   = (w_r2 >= w_d);
        w_diff = w_ge ? (w_r2 - w_d) : w_r2;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_rem  <= w_diff[cgrg_pkg::DEN_W-1:0];
            o_word <= {i_word[cgrg_pkg::QW-2:0], w_ge};
        end
    end

endmodule

FILE: src/complex_givens_rotation_generator.sv
// Complex Givens rotation generator: top level with front-end multipliers, normaliser,
// square-root and divider cell chains, output skid. Depends on cgrg_pkg and the cells.
//
// Takes one (f, g) request per cycle while the skid stage is empty and returns (c, s, r)
// through six multiply/add stages, six normalising stages, a 64-cell square-root chain (one root
// bit per cell), one numerator stage, five parallel 35-cell divider chains (one
// quotient bit per cell) and the output register. The pipeline halts whenever the skid
// stage behind the output is full.
module complex_givens_rotation_generator (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_s_axis_tvalid,
    output logic                              o_s_axis_tready,
    input  logic [cgrg_pkg::IN_DATA_W-1:0]    i_s_axis_tdata,   // f_re, f_im, g_re, g_im
    output logic                              o_m_axis_tvalid,
    input  logic                              i_m_axis_tready,
    output logic [cgrg_pkg::OUT_DATA_W-1:0]   o_m_axis_tdata    // cos_value, sin_re, sin_im,
                                                                // rot_re, rot_im, pad
);

    localparam int V_NORM = cgrg_pkg::FRONT + cgrg_pkg::NORM_STEPS - 1;
    localparam int V_ROOT = V_NORM + cgrg_pkg::ROOT_W;
    localparam int V_LAST = cgrg_pkg::NSTG - 1;

    logic                        w_en;
    logic [cgrg_pkg::NSTG-1:0]   r_vld;

    // front end
    logic signed [31:0] r1_fr, r1_fi, r1_gr, r1_gi;
    logic signed [63:0] r1_frr, r1_fii, r1_grr, r1_gii, r1_rg, r1_ig, r1_igr, r1_rgi;
    logic signed [31:0] r2_fr, r2_fi, r2_gr, r2_gi;
    logic [63:0]        r2_f2, r2_g2;
    logic signed [64:0] r2_pms, r2_pmi;
    logic signed [31:0] r3_fr, r3_fi, r3_gr, r3_gi;
    logic [64:0]        r3_t;
    logic [63:0]        r3_f2, r3_g2, r3_apms, r3_apmi;
    logic               r3_nms, r3_nmi;
    logic [31:0]        r3_afr, r3_afi;
    logic [63:0]        w3_apms, w3_apmi;
    logic signed [31:0] r4_fr, r4_fi, r4_gr, r4_gi;
    logic [63:0]        r4_m00, r4_m01, r4_ar0, r4_ai0;
    logic [64:0]        r4_m10, r4_m11, r4_ar1, r4_ai1;
    logic [63:0]        r4_f2, r4_g2, r4_apms, r4_apmi;
    logic               r4_nms, r4_nmi;
    logic signed [31:0] r5_fr, r5_fi, r5_gr, r5_gi;
    logic [65:0]        r5_mid;
    logic [127:0]       r5_base;
    logic [96:0]        r5_tr, r5_ti;
    logic [63:0]        r5_f2, r5_g2, r5_apms, r5_apmi;
    logic               r5_nms, r5_nmi;

    // normaliser
    logic [cgrg_pkg::RAD_W-1:0] r_nx [0:cgrg_pkg::NORM_STEPS];
    logic [cgrg_pkg::SHC_W-1:0] r_ns [0:cgrg_pkg::NORM_STEPS];
    cgrg_pkg::t_side            r_nd [0:cgrg_pkg::NORM_STEPS];
    cgrg_pkg::t_side            w_s6;

    // square root
    logic [cgrg_pkg::REM_W-1:0]  w_srem  [0:cgrg_pkg::ROOT_W];
    logic [cgrg_pkg::ROOT_W-1:0] w_sroot [0:cgrg_pkg::ROOT_W];
    logic [cgrg_pkg::RAD_W-1:0]  w_sx    [0:cgrg_pkg::ROOT_W];
    cgrg_pkg::t_side             w_sqsd0;
    cgrg_pkg::t_side             r_sqsd  [1:cgrg_pkg::ROOT_W];

    // divider
    logic [cgrg_pkg::DEN_W-1:0] r_prem  [0:cgrg_pkg::LANES-1];
    logic [cgrg_pkg::QW-1:0]    r_pword [0:cgrg_pkg::LANES-1];
    logic [cgrg_pkg::DEN_W-1:0] r_dden  [0:cgrg_pkg::QW];
    cgrg_pkg::t_side            r_dsd   [0:cgrg_pkg::QW];
    logic [cgrg_pkg::DEN_W-1:0] w_drem  [0:cgrg_pkg::LANES-1][0:cgrg_pkg::QW];
    logic [cgrg_pkg::QW-1:0]    w_dword [0:cgrg_pkg::LANES-1][0:cgrg_pkg::QW];

    // output
    logic [cgrg_pkg::OUT_DATA_W-1:0] w_fin;
    logic                            r_ovalid, n_ovalid, r_svalid, n_svalid;
    logic [cgrg_pkg::OUT_DATA_W-1:0] r_odata, n_odata, r_sdata, n_sdata;
    logic                            w_take, w_pv;

    assign w_en            = !r_svalid;
    assign o_s_axis_tready = !r_svalid;
    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tdata  = r_odata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else if (w_en) begin
            r_vld <= {r_vld[cgrg_pkg::NSTG-2:0], i_s_axis_tvalid};
        end
    end

    always_comb begin
        w3_apms = r2_pms[64] ? 64'(~r2_pms + 65'sd1) : r2_pms[63:0];
        w3_apmi = r2_pmi[64] ? 64'(~r2_pmi + 65'sd1) : r2_pmi[63:0];
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r1_fr  <= i_s_axis_tdata[31:0];
            r1_fi  <= i_s_axis_tdata[63:32];
            r1_gr  <= i_s_axis_tdata[95:64];
            r1_gi  <= i_s_axis_tdata[127:96];
            r1_frr <= 64'($signed(i_s_axis_tdata[31:0])) * 64'($signed(i_s_axis_tdata[31:0]));
            r1_fii <= 64'($signed(i_s_axis_tdata[63:32])) * 64'($signed(i_s_axis_tdata[63:32]));
            r1_grr <= 64'($signed(i_s_axis_tdata[95:64])) * 64'($signed(i_s_axis_tdata[95:64]));
            r1_gii <= 64'($signed(i_s_axis_tdata[127:96]))
                      * 64'($signed(i_s_axis_tdata[127:96]));
            r1_rg  <= 64'($signed(i_s_axis_tdata[31:0])) * 64'($signed(i_s_axis_tdata[95:64]));
            r1_ig  <= 64'($signed(i_s_axis_tdata[63:32]))
                      * 64'($signed(i_s_axis_tdata[127:96]));
            r1_igr <= 64'($signed(i_s_axis_tdata[63:32])) * 64'($signed(i_s_axis_tdata[95:64]));
            r1_rgi <= 64'($signed(i_s_axis_tdata[31:0])) * 64'($signed(i_s_axis_tdata[127:96]));

            r2_fr  <= r1_fr;
            r2_fi  <= r1_fi;
            r2_gr  <= r1_gr;
            r2_gi  <= r1_gi;
            r2_f2  <= $unsigned(r1_frr + r1_fii);
            r2_g2  <= $unsigned(r1_grr + r1_gii);
            r2_pms <= 65'(r1_rg) + 65'(r1_ig);
            r2_pmi <= 65'(r1_igr) - 65'(r1_rgi);

            r3_fr   <= r2_fr;
            r3_fi   <= r2_fi;
            r3_gr   <= r2_gr;
            r3_gi   <= r2_gi;
            r3_t    <= {1'b0, r2_f2} + {1'b0, r2_g2};
            r3_f2   <= r2_f2;
            r3_g2   <= r2_g2;
            r3_apms <= w3_apms;
            r3_apmi <= w3_apmi;
            r3_nms  <= r2_pms[64];
            r3_nmi  <= r2_pmi[64];
            r3_afr  <= r2_fr[31] ? (~r2_fr + 32'sd1) : r2_fr;
            r3_afi  <= r2_fi[31] ? (~r2_fi + 32'sd1) : r2_fi;

            r4_fr   <= r3_fr;
            r4_fi   <= r3_fi;
            r4_gr   <= r3_gr;
            r4_gi   <= r3_gi;
            r4_m00  <= 64'(r3_t[31:0]) * 64'(r3_f2[31:0]);
            r4_m01  <= 64'(r3_t[31:0]) * 64'(r3_f2[63:32]);
            r4_m10  <= 65'(r3_t[64:32]) * 65'(r3_f2[31:0]);
            r4_m11  <= 65'(r3_t[64:32]) * 65'(r3_f2[63:32]);
            r4_ar0  <= 64'(r3_t[31:0]) * 64'(r3_afr);
            r4_ar1  <= 65'(r3_t[64:32]) * 65'(r3_afr);
            r4_ai0  <= 64'(r3_t[31:0]) * 64'(r3_afi);
            r4_ai1  <= 65'(r3_t[64:32]) * 65'(r3_afi);
            r4_f2   <= r3_f2;
            r4_g2   <= r3_g2;
            r4_apms <= r3_apms;
            r4_apmi <= r3_apmi;
            r4_nms  <= r3_nms;
            r4_nmi  <= r3_nmi;

            r5_fr   <= r4_fr;
            r5_fi   <= r4_fi;
            r5_gr   <= r4_gr;
            r5_gi   <= r4_gi;
            r5_mid  <= 66'(r4_m01) + 66'(r4_m10);
            r5_base <= {r4_m11[63:0], r4_m00};
            r5_tr   <= {r4_ar1, 32'b0} + 97'(r4_ar0);
            r5_ti   <= {r4_ai1, 32'b0} + 97'(r4_ai0);
            r5_f2   <= r4_f2;
            r5_g2   <= r4_g2;
            r5_apms <= r4_apms;
            r5_apmi <= r4_apmi;
            r5_nms  <= r4_nms;
            r5_nmi  <= r4_nmi;
        end
    end

    logic w5_gz, w5_fz;
    logic [127:0] w5_m;
    logic [31:0]  w5_agr, w5_agi;

    always_comb begin
        w5_gz  = (r5_gr == '0) && (r5_gi == '0);
        w5_fz  = (r5_fr == '0) && (r5_fi == '0);
        w5_agr = r5_gr[31] ? (~r5_gr + 32'sd1) : r5_gr;
        w5_agi = r5_gi[31] ? (~r5_gi + 32'sd1) : r5_gi;
        w5_m   = w5_fz ? 128'(r5_g2) : (r5_base + (128'(r5_mid) << 32));
        w_s6.gz = w5_gz;
        w_s6.fr = r5_fr;
        w_s6.fi = r5_fi;
        w_s6.e  = '0;
        if (w5_fz) begin
            w_s6.num[cgrg_pkg::LANE_COS] = '0;
            w_s6.num[cgrg_pkg::LANE_SRE] = 96'(w5_agr);
            w_s6.num[cgrg_pkg::LANE_SIM] = 96'(w5_agi);
            w_s6.num[cgrg_pkg::LANE_RRE] = 96'(r5_g2);
            w_s6.num[cgrg_pkg::LANE_RIM] = '0;
            w_s6.neg[cgrg_pkg::LANE_COS] = 1'b0;
            w_s6.neg[cgrg_pkg::LANE_SRE] = r5_gr[31];
            w_s6.neg[cgrg_pkg::LANE_SIM] = !r5_gi[31] && (r5_gi != '0);
            w_s6.neg[cgrg_pkg::LANE_RRE] = 1'b0;
            w_s6.neg[cgrg_pkg::LANE_RIM] = 1'b0;
        end else begin
            w_s6.num[cgrg_pkg::LANE_COS] = 96'(r5_f2);
            w_s6.num[cgrg_pkg::LANE_SRE] = 96'(r5_apms);
            w_s6.num[cgrg_pkg::LANE_SIM] = 96'(r5_apmi);
            w_s6.num[cgrg_pkg::LANE_RRE] = r5_tr[95:0];
            w_s6.num[cgrg_pkg::LANE_RIM] = r5_ti[95:0];
            w_s6.neg[cgrg_pkg::LANE_COS] = 1'b0;
            w_s6.neg[cgrg_pkg::LANE_SRE] = r5_nms;
            w_s6.neg[cgrg_pkg::LANE_SIM] = r5_nmi;
            w_s6.neg[cgrg_pkg::LANE_RRE] = r5_fr[31];
            w_s6.neg[cgrg_pkg::LANE_RIM] = r5_fi[31];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_nx[0] <= w5_m;
            r_ns[0] <= '0;
            r_nd[0] <= w_s6;
        end
    end

    // normalise: even shifts, halving each stage
    for (genvar gk = 0; gk < cgrg_pkg::NORM_STEPS; gk++) begin : g_norm
        localparam int SH = 64 >> gk;
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                if (r_nx[gk][cgrg_pkg::RAD_W-1 -: SH] == '0) begin
                    r_nx[gk+1] <= r_nx[gk] << SH;
                    r_ns[gk+1] <= r_ns[gk] + cgrg_pkg::SHC_W'(SH);
                end else begin
                    r_nx[gk+1] <= r_nx[gk];
                    r_ns[gk+1] <= r_ns[gk];
                end
                r_nd[gk+1] <= r_nd[gk];
            end
        end
    end

    always_comb begin
        w_sqsd0   = r_nd[cgrg_pkg::NORM_STEPS];
        w_sqsd0.e = r_ns[cgrg_pkg::NORM_STEPS][cgrg_pkg::SHC_W-1:1];
    end

    assign w_srem[0]  = '0;
    assign w_sroot[0] = '0;
    assign w_sx[0]    = r_nx[cgrg_pkg::NORM_STEPS];

    for (genvar gk = 0; gk < cgrg_pkg::ROOT_W; gk++) begin : g_sqrt
        cgrg_sqrt_cell u_cell (
            .i_clk  (i_clk),
            .i_en   (w_en),
            .i_rem  (w_srem[gk]),
            .i_root (w_sroot[gk]),
            .i_x    (w_sx[gk]),
            .o_rem  (w_srem[gk+1]),
            .o_root (w_sroot[gk+1]),
            .o_x    (w_sx[gk+1])
        );
        if (gk == 0) begin : g_first
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sqsd[1] <= w_sqsd0;
                end
            end
        end else begin : g_rest
            always_ff @(posedge i_clk) begin
                if (w_en) begin
                    r_sqsd[gk+1] <= r_sqsd[gk];
                end
            end
        end
    end

    // scaled numerators: 2*|N|*2^sh + D, split into leading remainder and dividend bits
    for (genvar gl = 0; gl < cgrg_pkg::LANES; gl++) begin : g_prep
        localparam logic [cgrg_pkg::SHC_W-1:0] BASE = (gl < cgrg_pkg::LANE_RRE) ? 7'd31 : 7'd1;
        logic [cgrg_pkg::SHC_W-1:0] w_amt;
        logic [cgrg_pkg::N2_W-1:0]  w_n2;
        always_comb begin
            w_amt = cgrg_pkg::SHC_W'(r_sqsd[cgrg_pkg::ROOT_W].e) + BASE;
            w_n2  = (cgrg_pkg::N2_W'(r_sqsd[cgrg_pkg::ROOT_W].num[gl]) << w_amt)
                    + cgrg_pkg::N2_W'(w_sroot[cgrg_pkg::ROOT_W]);
        end
        always_ff @(posedge i_clk) begin
            if (w_en) begin
                r_prem[gl]  <= w_n2[cgrg_pkg::N2_W-1:cgrg_pkg::QW];
                r_pword[gl] <= w_n2[cgrg_pkg::QW-1:0];
            end
        end
        assign w_drem[gl][0]  = r_prem[gl];
        assign w_dword[gl][0] = r_pword[gl];
        for (genvar gj = 0; gj < cgrg_pkg::QW; gj++) begin : g_div
            cgrg_div_cell u_cell (
                .i_clk  (i_clk),
                .i_en   (w_en),
                .i_rem  (w_drem[gl][gj]),
                .i_word (w_dword[gl][gj]),
                .i_den  (r_dden[gj]),
                .o_rem  (w_drem[gl][gj+1]),
                .o_word (w_dword[gl][gj+1])
            );
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_en) begin
            r_dden[0] <= {w_sroot[cgrg_pkg::ROOT_W], 1'b0};
            r_dsd[0]  <= r_sqsd[cgrg_pkg::ROOT_W];
            for (int k = 0; k < cgrg_pkg::QW; k++) begin
                r_dden[k+1] <= r_dden[k];
                r_dsd[k+1]  <= r_dsd[k];
            end
        end
    end

    logic [cgrg_pkg::Q30_W-1:0] w_c, w_sr, w_si;
    logic [cgrg_pkg::ROT_W-1:0] w_rr, w_ri, w_gfr, w_gfi;
    cgrg_pkg::t_side            w_ls;

    always_comb begin
        w_ls  = r_dsd[cgrg_pkg::QW];
        w_gfr = cgrg_pkg::ROT_W'(w_ls.fr);
        w_gfi = cgrg_pkg::ROT_W'(w_ls.fi);
        if (w_ls.gz) begin
            w_c  = w_ls.fr[31] ? cgrg_pkg::q30_clamp(1'b1, cgrg_pkg::ONE_Q30)
                               : cgrg_pkg::ONE_Q30[cgrg_pkg::Q30_W-1:0];
            w_sr = '0;
            w_si = '0;
            w_rr = w_ls.fr[31] ? (~w_gfr + cgrg_pkg::ROT_W'(1)) : w_gfr;
            w_ri = w_ls.fr[31] ? (~w_gfi + cgrg_pkg::ROT_W'(1)) : w_gfi;
        end else begin
            w_c  = cgrg_pkg::q30_clamp(w_ls.neg[cgrg_pkg::LANE_COS],
                                       w_dword[cgrg_pkg::LANE_COS][cgrg_pkg::QW]);
            w_sr = cgrg_pkg::q30_clamp(w_ls.neg[cgrg_pkg::LANE_SRE],
                                       w_dword[cgrg_pkg::LANE_SRE][cgrg_pkg::QW]);
            w_si = cgrg_pkg::q30_clamp(w_ls.neg[cgrg_pkg::LANE_SIM],
                                       w_dword[cgrg_pkg::LANE_SIM][cgrg_pkg::QW]);
            w_rr = cgrg_pkg::rot_sign(w_ls.neg[cgrg_pkg::LANE_RRE],
                                      w_dword[cgrg_pkg::LANE_RRE][cgrg_pkg::QW]);
            w_ri = cgrg_pkg::rot_sign(w_ls.neg[cgrg_pkg::LANE_RIM],
                                      w_dword[cgrg_pkg::LANE_RIM][cgrg_pkg::QW]);
        end
        w_fin = {4'b0, w_ri, w_rr, w_si, w_sr, w_c};
    end

    // output register with skid
    always_comb begin
        w_take   = !r_ovalid || i_m_axis_tready;
        w_pv     = r_vld[V_LAST] && w_en;
        n_ovalid = r_ovalid;
        n_odata  = r_odata;
        n_svalid = r_svalid;
        n_sdata  = r_sdata;
        if (w_take) begin
            if (r_svalid) begin
                n_ovalid = 1'b1;
                n_odata  = r_sdata;
                n_svalid = 1'b0;
            end else begin
                n_ovalid = w_pv;
                n_odata  = w_fin;
            end
        end else if (w_pv) begin
            n_svalid = 1'b1;
            n_sdata  = w_fin;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
            r_svalid <= 1'b0;
        end else begin
            r_ovalid <= n_ovalid;
            r_svalid <= n_svalid;
        end
        r_odata <= n_odata;
        r_sdata <= n_sdata;
    end

    a_skid_behind_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_svalid |-> r_ovalid)
        else $error("skid request held without an output request");

    a_norm_top: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[V_NORM] && (r_nx[cgrg_pkg::NORM_STEPS] != '0))
            |-> (r_nx[cgrg_pkg::NORM_STEPS][cgrg_pkg::RAD_W-1 -: 2] != 2'b00))
        else $error("normaliser left leading zero pair");

    a_root_msb: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_vld[V_ROOT] && !r_sqsd[cgrg_pkg::ROOT_W].gz)
            |-> w_sroot[cgrg_pkg::ROOT_W][cgrg_pkg::ROOT_W-1])
        else $error("root not normalised for a rotating request");

endmodule

FILE: test/tb_complex_givens_rotation_generator.sv
// Testbench for the complex Givens rotation generator: directed corner requests, then random
// ones under varying source gaps and sink stalls, each result checked against a local predictor.
// Depends on the RTL in src only.
`timescale 1ns / 1ps

module tb_complex_givens_rotation_generator;

    localparam int LATENCY     = 113;
    localparam int WATCH_LIMIT = 4000;
    localparam int LONG_HOLD   = 600;

    typedef struct packed {
        logic [31:0] cos_value;
        logic [31:0] sin_re;
        logic [31:0] sin_im;
        logic [33:0] rot_re;
        logic [33:0] rot_im;
    } rotation_t;

    logic         i_clk = 1'b0;
    logic         i_rst_n = 1'b0;
    logic         i_s_axis_tvalid = 1'b0;
    logic         o_s_axis_tready;
    logic [127:0] i_s_axis_tdata = '0;   // f_re, f_im, g_re, g_im
    logic         o_m_axis_tvalid;
    logic         i_m_axis_tready = 1'b0;
    logic [167:0] o_m_axis_tdata;        // cos_value, sin_re, sin_im, rot_re, rot_im, pad

    rotation_t rotation_q[$];
    int        mismatches = 0;
    int        send_idle_pct = 0;
    int        stall_pct = 0;
    int        hold_left = 0;
    int        quiet_cycles = 0;

    complex_givens_rotation_generator uut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    function automatic bit [63:0] norm_root(input bit [127:0] m, output int e);
        int          top;
        bit [127:0]  x;
        bit [63:0]   res;
        bit [63:0]   cand;
        top = -1;
        for (int i = 127; i >= 0; i--) begin
            if (top < 0 && m[i]) top = i;
        end
        e = (127 - top) / 2;
        x = m << (2 * e);
        res = '0;
        for (int b = 63; b >= 0; b--) begin
            cand = res | (64'd1 << b);
            if (({64'd0, cand} * {64'd0, cand}) <= x) res = cand;
        end
        return res;
    endfunction

    function automatic bit [39:0] round_div(input bit [127:0] num, input int sh,
                                            input bit [63:0] den);
        bit [255:0] n2;
        bit [255:0] d2;
        bit [255:0] q;
        n2 = ({128'd0, num} << (sh + 1)) + {192'd0, den};
        d2 = {191'd0, den, 1'b0};
        q = n2 / d2;
        return q[39:0];
    endfunction

    function automatic logic [31:0] q30_out(input bit neg, input bit [39:0] q);
        bit [39:0] m;
        m = (q > 40'd1073741824) ? 40'd1073741824 : q;
        return neg ? 32'(-m) : m[31:0];
    endfunction

    function automatic logic [33:0] rot_out(input bit neg, input bit [39:0] q);
        return neg ? 34'(-q) : q[33:0];
    endfunction

    function automatic rotation_t predict_rotation(input logic [127:0] d);
        logic signed [65:0] fr, fi, gr, gi, pr, pi;
        bit [63:0]          mfr, mfi, mgr, mgi, f2, g2, den;
        bit [127:0]         tot;
        int                 e;
        rotation_t          r;
        fr = $signed(d[31:0]);
        fi = $signed(d[63:32]);
        gr = $signed(d[95:64]);
        gi = $signed(d[127:96]);
        mfr = fr < 0 ? 64'(-fr) : 64'(fr);
        mfi = fi < 0 ? 64'(-fi) : 64'(fi);
        mgr = gr < 0 ? 64'(-gr) : 64'(gr);
        mgi = gi < 0 ? 64'(-gi) : 64'(gi);
        f2 = mfr * mfr + mfi * mfi;
        g2 = mgr * mgr + mgi * mgi;
        r = '0;
        if (gr == 0 && gi == 0) begin
            r.cos_value = fr >= 0 ? 32'h4000_0000 : 32'hC000_0000;
            r.rot_re = fr >= 0 ? 34'(fr) : 34'(-fr);
            r.rot_im = fr >= 0 ? 34'(fi) : 34'(-fi);
        end else if (fr == 0 && fi == 0) begin
            den = norm_root({64'd0, g2}, e);
            r.sin_re = q30_out(gr < 0, round_div({64'd0, mgr}, 30 + e, den));
            r.sin_im = q30_out(gi > 0, round_div({64'd0, mgi}, 30 + e, den));
            r.rot_re = rot_out(1'b0, round_div({64'd0, g2}, e, den));
        end else begin
            tot = {64'd0, f2} + {64'd0, g2};
            den = norm_root(tot * {64'd0, f2}, e);
            r.cos_value = q30_out(1'b0, round_div({64'd0, f2}, 30 + e, den));
            pr = fr * gr + fi * gi;
            pi = fi * gr - fr * gi;
            r.sin_re = q30_out(pr < 0, round_div(128'(pr < 0 ? -pr : pr), 30 + e, den));
            r.sin_im = q30_out(pi < 0, round_div(128'(pi < 0 ? -pi : pi), 30 + e, den));
            r.rot_re = rot_out(fr < 0, round_div(tot * {64'd0, mfr}, e, den));
            r.rot_im = rot_out(fi < 0, round_div(tot * {64'd0, mfi}, e, den));
        end
        return r;
    endfunction

    function automatic void report_field(input string name, input logic [33:0] want,
                                         input logic [33:0] got);
        if (want !== got) begin
            mismatches++;
            if (mismatches <= 10)
                $display("mismatch %s: expected %h got %h", name, want, got);
        end
    endfunction

    // predict on input acceptance, compare on output acceptance
    always @(posedge i_clk) begin
        rotation_t want;
        if (i_rst_n && i_s_axis_tvalid && o_s_axis_tready)
            rotation_q.push_back(predict_rotation(i_s_axis_tdata));
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (rotation_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("mismatch: result with nothing outstanding");
            end else begin
                want = rotation_q.pop_front();
                report_field("cos_value", 34'(want.cos_value), 34'(o_m_axis_tdata[31:0]));
                report_field("sin_re", 34'(want.sin_re), 34'(o_m_axis_tdata[63:32]));
                report_field("sin_im", 34'(want.sin_im), 34'(o_m_axis_tdata[95:64]));
                report_field("rot_re", want.rot_re, o_m_axis_tdata[129:96]);
                report_field("rot_im", want.rot_im, o_m_axis_tdata[163:130]);
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_m_axis_tready <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= ($urandom_range(0, 99) >= stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_s_axis_tvalid && o_s_axis_tready) || (o_m_axis_tvalid && i_m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCH_LIMIT) begin
            $display("CHECKS FAILED");
            $finish;
        end
    end

    task automatic send_request(input logic [31:0] fr, input logic [31:0] fi,
                                input logic [31:0] gr, input logic [31:0] gi);
        if (send_idle_pct > 0 && $urandom_range(0, 99) < send_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
            while ($urandom_range(0, 99) < send_idle_pct) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata <= {gi, gr, fi, fr};
        @(posedge i_clk);
        while (!o_s_axis_tready) @(posedge i_clk);
    endtask

    task automatic drain;
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (rotation_q.size() != 0) @(posedge i_clk);
    endtask

    function automatic logic [31:0] pick_part(input int kind);
        logic [31:0] corners[6] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
                                    32'h8000_0000, 32'h0001_0000};
        case (kind)
            0: return $urandom;
            1: return 32'($signed($urandom_range(0, 512)) - 256);
            2: return corners[$urandom_range(0, 5)];
            default: return 32'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
        endcase
    endfunction

    task automatic random_requests(input int count);
        logic [31:0] v[4];
        int          mode;
        for (int n = 0; n < count; n++) begin
            mode = $urandom_range(0, 3);
            foreach (v[k]) v[k] = pick_part($urandom_range(0, 3) == 0 ? mode : 0);
            case ($urandom_range(0, 9))
                0: begin v[2] = '0; v[3] = '0; end
                1: begin v[0] = '0; v[1] = '0; end
                2: v[$urandom_range(0, 3)] = '0;
                default: ;
            endcase
            send_request(v[0], v[1], v[2], v[3]);
        end
    endtask

    task automatic test_corners;
        logic [31:0] vals[5] = '{32'h0, 32'h1, 32'hFFFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000};
        send_idle_pct = 0;
        stall_pct = 0;
        send_request(0, 0, 0, 0);
        send_request(32'h0001_0000, 32'h5, 0, 0);
        send_request(32'hFFFF_0000, 32'h7FFF_FFFF, 0, 0);
        send_request(32'h8000_0000, 32'h8000_0000, 0, 0);
        send_request(0, 32'h3, 0, 0);
        send_request(0, 0, 32'h0003_0000, 32'hFFFC_0000);
        send_request(0, 0, 32'h1, 0);
        send_request(0, 0, 0, 32'hFFFF_FFFF);
        send_request(0, 0, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
        send_request(32'h1, 0, 32'h8000_0000, 32'h7FFF_FFFF);
        send_request(32'h8000_0000, 32'h7FFF_FFFF, 32'h1, 32'hFFFF_FFFF);
        foreach (vals[k])
            send_request(vals[k], vals[(k + 1) % 5], vals[(k + 2) % 5], vals[(k + 3) % 5]);
        send_request(32'h0001_0000, 32'h0001_0000, 32'h0001_0000, 32'hFFFF_0000);
        drain();
    endtask

    task automatic test_phase(input int idle, input int stall, input int count);
        send_idle_pct = idle;
        stall_pct = stall;
        random_requests(count);
        drain();
    endtask

    task automatic test_backpressure;
        send_idle_pct = 0;
        stall_pct = 0;
        hold_left = LONG_HOLD;
        random_requests(300);
        drain();
    endtask

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        test_corners();
        test_phase(0, 0, 500);
        test_phase(87, 0, 300);
        test_phase(0, 87, 300);
        test_phase(9, 9, 500);
        test_backpressure();
        repeat (LATENCY + 20) @(posedge i_clk);
        if (mismatches == 0 && rotation_q.size() == 0)
            $display("ALL CHECKS PASSED");
        else
            $display("CHECKS FAILED");
        $finish;
    end

endmodule
